[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// Both macros sample on the rising edge of clk.
// ASSERT_CLK checks only outside reset; ASSERT_CLK_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_CLK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_CLK_ALWAYS(lbl, prop)

`endif

`endif

[sv/obot_pkg.sv]
`default_nettype none

package obot_pkg;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int DIR_W    = 16;
  localparam int HALF_W   = 31;
  localparam int MARGIN_W = 24;

  // Datapath widths
  localparam int DIFF_W = 33;  // center difference, extents
  localparam int COS_W  = 32;  // |cos| and |sin| in Q.28, at most 2^31
  localparam int PROJ_W = 49;  // |projection| in Q.14, at most 2^48
  localparam int TERM_W = 50;  // floored cross term in Q.14
  localparam int RAD_W  = 52;  // projected radius sum

  localparam int FRAC_SHIFT = 14;

  // Stream widths
  localparam int IN_TDATA_W  = 248;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_DIR_X       = 3'd2,
    REG_DIR_Y       = 3'd3,
    REG_HALF_LENGTH = 3'd4,
    REG_HALF_WIDTH  = 3'd5,
    REG_Z_LOW       = 3'd6,
    REG_Z_HIGH      = 3'd7
  } cfg_reg_t;

  localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;

  // Load enables for the two stages inside one axis unit
  typedef struct packed {
    logic term;   // cross-term stage
    logic cmp;    // radius compare stage
  } stage_en_t;

endpackage

`default_nettype wire

[sv/obot_axis.sv]
`default_nettype none

// One separating axis: two cross terms, radius sum and compare, two stages.
module obot_axis (
  input  wire                                    clk,
  input  obot_pkg::stage_en_t                    en,
  input  wire        [obot_pkg::PROJ_W-1:0]      proj,
  input  wire signed [obot_pkg::DIFF_W-1:0]      own_ext,
  input  wire        [obot_pkg::COS_W-1:0]       k1,
  input  wire signed [obot_pkg::DIFF_W-1:0]      e1,
  input  wire        [obot_pkg::COS_W-1:0]       k2,
  input  wire signed [obot_pkg::DIFF_W-1:0]      e2,
  output logic                                   sep
);

  localparam int PROD_W = 2 * obot_pkg::DIFF_W;

  logic signed [PROD_W-1:0]               prod1;
  logic signed [PROD_W-1:0]               prod2;
  logic signed [obot_pkg::TERM_W-1:0]     term1;
  logic signed [obot_pkg::TERM_W-1:0]     term2;
  logic signed [obot_pkg::DIFF_W-1:0]     own_q;
  logic        [obot_pkg::PROJ_W-1:0]     proj_q;
  logic signed [obot_pkg::RAD_W-1:0]      rad;
  logic signed [obot_pkg::RAD_W-1:0]      proj_ext;

  // Cross terms in Q.28, floored to Q.14 by an arithmetic shift
  assign prod1 = $signed({1'b0, k1}) * e1;
  assign prod2 = $signed({1'b0, k2}) * e2;

  always_ff @(posedge clk) begin
    if (en.term) begin
      term1  <= prod1[obot_pkg::FRAC_SHIFT +: obot_pkg::TERM_W];
      term2  <= prod2[obot_pkg::FRAC_SHIFT +: obot_pkg::TERM_W];
      own_q  <= own_ext;
      proj_q <= proj;
    end
  end

  // Radius sum; an axis with zero projection never separates
  always_comb begin
    rad = $signed({{(obot_pkg::RAD_W - obot_pkg::DIFF_W - obot_pkg::FRAC_SHIFT){own_q[obot_pkg::DIFF_W-1]}},
                   own_q, {obot_pkg::FRAC_SHIFT{1'b0}}})
        + $signed({{(obot_pkg::RAD_W - obot_pkg::TERM_W){term1[obot_pkg::TERM_W-1]}}, term1})
        + $signed({{(obot_pkg::RAD_W - obot_pkg::TERM_W){term2[obot_pkg::TERM_W-1]}}, term2});
    proj_ext = $signed({{(obot_pkg::RAD_W - obot_pkg::PROJ_W){1'b0}}, proj_q});
  end

  always_ff @(posedge clk) begin
    if (en.cmp) begin
      sep <= (proj_q != '0) && (rad <= proj_ext);
    end
  end

endmodule

`default_nettype wire

[sv/oriented_box_overlap_test_top.sv]
// Oriented box overlap test.
// A reference box sits in eight configuration registers written through the
// cfg channel (cfg_index selects the register, cfg_data carries the value,
// cfg_ready is always high). Write them only while no item is in flight.
// Each transfer on the s_axis channel carries one tested box and a margin;
// each transfer on the m_axis channel returns one overlap flag, in order.
// Each item passes through a six-stage pipeline (differences, products,
// magnitudes, cross-term multipliers, radius compare, output register).
// Throughput: one item per cycle while the receiver keeps m_axis_tready high.
// When the receiver holds m_axis_tready low, stages fill up behind the
// output register and s_axis_tready drops once every stage holds an item;
// bubbles are squeezed out, nothing is lost or repeated.
// Reset (rst, synchronous, active high) empties the pipeline and sets the
// reference box to direction (1, 0) with all other registers zero.
`default_nettype none

`include "assert_macros.svh"

module oriented_box_overlap_test_top (
  input  wire                                    clk,
  input  wire                                    rst,
  // configuration write channel
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [obot_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [31:0]                            cfg_data,
  // input stream
  input  wire                                    s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] other_center_x, [63:32] other_center_y, [79:64] other_dir_x,
  // [95:80] other_dir_y, [126:96] other_half_length,
  // [157:127] other_half_width, [189:158] other_z_low,
  // [221:190] other_z_high, [245:222] margin, [247:246] zero
  input  wire  [obot_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire                                    m_axis_tready,
  // [0] overlap, [7:1] zero
  output logic [obot_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  localparam int DW = obot_pkg::DIFF_W;
  localparam int PW = obot_pkg::PROJ_W;
  localparam int CW = obot_pkg::COS_W;
  localparam int MW = obot_pkg::MARGIN_W;
  localparam int XW = obot_pkg::DIR_W;
  localparam int PRD_W = DW + XW;       // coordinate by direction product
  localparam int SUM_W = PRD_W + 1;
  localparam int DD_W  = 2 * XW;        // direction by direction product

  // Configuration registers
  logic signed [obot_pkg::COORD_W-1:0] self_center_x;
  logic signed [obot_pkg::COORD_W-1:0] self_center_y;
  logic signed [XW-1:0]                self_dir_x;
  logic signed [XW-1:0]                self_dir_y;
  logic        [obot_pkg::HALF_W-1:0]  self_half_length;
  logic        [obot_pkg::HALF_W-1:0]  self_half_width;
  logic signed [obot_pkg::COORD_W-1:0] self_z_low;
  logic signed [obot_pkg::COORD_W-1:0] self_z_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_center_x    <= '0;
      self_center_y    <= '0;
      self_dir_x       <= obot_pkg::DIR_X_RESET;
      self_dir_y       <= '0;
      self_half_length <= '0;
      self_half_width  <= '0;
      self_z_low       <= '0;
      self_z_high      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (obot_pkg::cfg_reg_t'(cfg_index))
        obot_pkg::REG_CENTER_X:    self_center_x    <= cfg_data;
        obot_pkg::REG_CENTER_Y:    self_center_y    <= cfg_data;
        obot_pkg::REG_DIR_X:       self_dir_x       <= cfg_data[XW-1:0];
        obot_pkg::REG_DIR_Y:       self_dir_y       <= cfg_data[XW-1:0];
        obot_pkg::REG_HALF_LENGTH: self_half_length <= cfg_data[obot_pkg::HALF_W-1:0];
        obot_pkg::REG_HALF_WIDTH:  self_half_width  <= cfg_data[obot_pkg::HALF_W-1:0];
        obot_pkg::REG_Z_LOW:       self_z_low       <= cfg_data;
        obot_pkg::REG_Z_HIGH:      self_z_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when it drains
  logic [5:1] vld;
  logic [6:1] ld;

  always_comb begin
    ld[6] = !m_axis_tvalid || m_axis_tready;
    ld[5] = !vld[5] || ld[6];
    ld[4] = !vld[4] || ld[5];
    ld[3] = !vld[3] || ld[4];
    ld[2] = !vld[2] || ld[3];
    ld[1] = !vld[1] || ld[2];
  end

  assign s_axis_tready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ld[1]) vld[1] <= s_axis_tvalid;
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
      if (ld[5]) vld[5] <= vld[4];
      if (ld[6]) m_axis_tvalid <= vld[5];
    end
  end

  // Unpack the input transfer
  logic signed [obot_pkg::COORD_W-1:0] in_cx;
  logic signed [obot_pkg::COORD_W-1:0] in_cy;
  logic signed [XW-1:0]                in_dx;
  logic signed [XW-1:0]                in_dy;
  logic        [obot_pkg::HALF_W-1:0]  in_hl;
  logic        [obot_pkg::HALF_W-1:0]  in_hw;
  logic signed [obot_pkg::COORD_W-1:0] in_zl;
  logic signed [obot_pkg::COORD_W-1:0] in_zh;
  logic signed [MW-1:0]                in_m;

  always_comb begin
    in_cx = s_axis_tdata[31:0];
    in_cy = s_axis_tdata[63:32];
    in_dx = s_axis_tdata[79:64];
    in_dy = s_axis_tdata[95:80];
    in_hl = s_axis_tdata[126:96];
    in_hw = s_axis_tdata[157:127];
    in_zl = s_axis_tdata[189:158];
    in_zh = s_axis_tdata[221:190];
    in_m  = s_axis_tdata[245:222];
  end

  // Stage 1: center difference, widened extents, height interval test
  logic signed [DW-1:0] m_ext;
  logic signed [DW-1:0] z_top_o;
  logic signed [DW-1:0] z_bot_s;
  logic signed [DW-1:0] z_bot_o;
  logic signed [DW-1:0] z_top_s;

  logic signed [DW-1:0] s1_dx;
  logic signed [DW-1:0] s1_dy;
  logic signed [XW-1:0] s1_odx;
  logic signed [XW-1:0] s1_ody;
  logic signed [DW-1:0] s1_es_l;
  logic signed [DW-1:0] s1_es_w;
  logic signed [DW-1:0] s1_eo_l;
  logic signed [DW-1:0] s1_eo_w;
  logic                 s1_hz;

  always_comb begin
    m_ext   = {{(DW - MW){in_m[MW-1]}}, in_m};
    z_top_o = {in_zh[31], in_zh} + m_ext;
    z_bot_s = {self_z_low[31], self_z_low} - m_ext;
    z_bot_o = {in_zl[31], in_zl} - m_ext;
    z_top_s = {self_z_high[31], self_z_high} + m_ext;
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_dx   <= {self_center_x[31], self_center_x} - {in_cx[31], in_cx};
      s1_dy   <= {self_center_y[31], self_center_y} - {in_cy[31], in_cy};
      s1_odx  <= in_dx;
      s1_ody  <= in_dy;
      s1_es_l <= $signed({2'b00, self_half_length}) + m_ext;
      s1_es_w <= $signed({2'b00, self_half_width}) + m_ext;
      s1_eo_l <= $signed({2'b00, in_hl}) + m_ext;
      s1_eo_w <= $signed({2'b00, in_hw}) + m_ext;
      s1_hz   <= !((z_top_o < z_bot_s) || (z_bot_o > z_top_s));
    end
  end

  // Stage 2: projections on four axes, cosine and sine of the two directions
  logic signed [PRD_W-1:0] pr_dx_sx, pr_dy_sy, pr_dy_sx, pr_dx_sy;
  logic signed [PRD_W-1:0] pr_dx_ox, pr_dy_oy, pr_dy_ox, pr_dx_oy;
  logic signed [DD_W-1:0]  dd_xx, dd_yy, dd_xy, dd_yx;

  logic signed [SUM_W-1:0] s2_p_sd, s2_p_sn, s2_p_od, s2_p_on;
  logic signed [DW-1:0]    s2_c;
  logic signed [DW-1:0]    s2_s;
  logic signed [DW-1:0]    s2_es_l, s2_es_w, s2_eo_l, s2_eo_w;
  logic                    s2_hz;

  always_comb begin
    pr_dx_sx = s1_dx * self_dir_x;
    pr_dy_sy = s1_dy * self_dir_y;
    pr_dy_sx = s1_dy * self_dir_x;
    pr_dx_sy = s1_dx * self_dir_y;
    pr_dx_ox = s1_dx * s1_odx;
    pr_dy_oy = s1_dy * s1_ody;
    pr_dy_ox = s1_dy * s1_odx;
    pr_dx_oy = s1_dx * s1_ody;
    dd_xx    = self_dir_x * s1_odx;
    dd_yy    = self_dir_y * s1_ody;
    dd_xy    = self_dir_x * s1_ody;
    dd_yx    = self_dir_y * s1_odx;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_p_sd <= {pr_dx_sx[PRD_W-1], pr_dx_sx} + {pr_dy_sy[PRD_W-1], pr_dy_sy};
      s2_p_sn <= {pr_dy_sx[PRD_W-1], pr_dy_sx} - {pr_dx_sy[PRD_W-1], pr_dx_sy};
      s2_p_od <= {pr_dx_ox[PRD_W-1], pr_dx_ox} + {pr_dy_oy[PRD_W-1], pr_dy_oy};
      s2_p_on <= {pr_dy_ox[PRD_W-1], pr_dy_ox} - {pr_dx_oy[PRD_W-1], pr_dx_oy};
      s2_c    <= {dd_xx[DD_W-1], dd_xx} + {dd_yy[DD_W-1], dd_yy};
      s2_s    <= {dd_xy[DD_W-1], dd_xy} - {dd_yx[DD_W-1], dd_yx};
      s2_es_l <= s1_es_l;
      s2_es_w <= s1_es_w;
      s2_eo_l <= s1_eo_l;
      s2_eo_w <= s1_eo_w;
      s2_hz   <= s1_hz;
    end
  end

  // Stage 3: magnitudes
  logic [SUM_W-1:0] ab_sd, ab_sn, ab_od, ab_on;
  logic [DW-1:0]    ab_c, ab_s;

  always_comb begin
    ab_sd = s2_p_sd[SUM_W-1] ? (~s2_p_sd + 1'b1) : s2_p_sd;
    ab_sn = s2_p_sn[SUM_W-1] ? (~s2_p_sn + 1'b1) : s2_p_sn;
    ab_od = s2_p_od[SUM_W-1] ? (~s2_p_od + 1'b1) : s2_p_od;
    ab_on = s2_p_on[SUM_W-1] ? (~s2_p_on + 1'b1) : s2_p_on;
    ab_c  = s2_c[DW-1] ? (~s2_c + 1'b1) : s2_c;
    ab_s  = s2_s[DW-1] ? (~s2_s + 1'b1) : s2_s;
  end

  logic [PW-1:0]        s3_p_sd, s3_p_sn, s3_p_od, s3_p_on;
  logic [CW-1:0]        s3_c, s3_s;
  logic signed [DW-1:0] s3_es_l, s3_es_w, s3_eo_l, s3_eo_w;
  logic                 s3_hz;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_p_sd <= ab_sd[PW-1:0];
      s3_p_sn <= ab_sn[PW-1:0];
      s3_p_od <= ab_od[PW-1:0];
      s3_p_on <= ab_on[PW-1:0];
      s3_c    <= ab_c[CW-1:0];
      s3_s    <= ab_s[CW-1:0];
      s3_es_l <= s2_es_l;
      s3_es_w <= s2_es_w;
      s3_eo_l <= s2_eo_l;
      s3_eo_w <= s2_eo_w;
      s3_hz   <= s2_hz;
    end
  end

  // Stages 4 and 5: one unit per axis
  obot_pkg::stage_en_t axis_en;
  logic [3:0]          sep;

  assign axis_en.term = ld[4];
  assign axis_en.cmp  = ld[5];

  obot_axis u_axis_self_dir (
    .clk     (clk),
    .en      (axis_en),
    .proj    (s3_p_sd),
    .own_ext (s3_es_l),
    .k1      (s3_c),
    .e1      (s3_eo_l),
    .k2      (s3_s),
    .e2      (s3_eo_w),
    .sep     (sep[0])
  );

  obot_axis u_axis_self_nrm (
    .clk     (clk),
    .en      (axis_en),
    .proj    (s3_p_sn),
    .own_ext (s3_es_w),
    .k1      (s3_s),
    .e1      (s3_eo_l),
    .k2      (s3_c),
    .e2      (s3_eo_w),
    .sep     (sep[1])
  );

  obot_axis u_axis_other_dir (
    .clk     (clk),
    .en      (axis_en),
    .proj    (s3_p_od),
    .own_ext (s3_eo_l),
    .k1      (s3_c),
    .e1      (s3_es_l),
    .k2      (s3_s),
    .e2      (s3_es_w),
    .sep     (sep[2])
  );

  obot_axis u_axis_other_nrm (
    .clk     (clk),
    .en      (axis_en),
    .proj    (s3_p_on),
    .own_ext (s3_eo_w),
    .k1      (s3_s),
    .e1      (s3_es_l),
    .k2      (s3_c),
    .e2      (s3_es_w),
    .sep     (sep[3])
  );

  // Carry the height result alongside the axis units
  logic s4_hz;
  logic s5_hz;

  always_ff @(posedge clk) begin
    if (ld[4]) s4_hz <= s3_hz;
    if (ld[5]) s5_hz <= s4_hz;
  end

  // Stage 6: output register
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      m_axis_tdata <= {{(obot_pkg::OUT_TDATA_W - 1){1'b0}}, (s5_hz && (sep == 4'b0000))};
    end
  end

  // Reset empties the output stage
  `ASSERT_CLK_ALWAYS(a_reset_empties_out, rst |=> !m_axis_tvalid)
  // A new result only appears from a filled last compute stage
  `ASSERT_CLK(a_out_from_stage5, $rose(m_axis_tvalid) |-> $past(vld[5]))
  // An empty pipeline always takes input
  `ASSERT_CLK(a_empty_ready, (vld == 5'b00000 && !m_axis_tvalid) |-> s_axis_tready)
  // A stalled output freezes input acceptance once every stage is full
  `ASSERT_CLK(a_full_stall, (vld == 5'b11111 && m_axis_tvalid && !m_axis_tready)
                            |-> !s_axis_tready)

endmodule

`default_nettype wire

[tb/oriented_box_overlap_test_top_tb.sv]
`timescale 1ns / 1ps

module oriented_box_overlap_test_top_tb;
  import obot_pkg::*;

  localparam longint UNIT        = 16384;        // 1.0 in Q1.14
  localparam longint MAX_HALF    = 'h7FFF_FFFF;
  localparam longint MARGIN_MAX  = 8388607;
  localparam longint MARGIN_MIN  = -8388608;
  localparam int     HOLD_CYCLES = 300;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 150;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic        [30:0] hl;
    logic        [30:0] hw;
    logic signed [31:0] zl;
    logic signed [31:0] zh;
    logic signed [23:0] margin;
  } box_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [IN_TDATA_W-1:0] box_pending[$];
  bit                    overlap_expected[$];
  box_t                  ref_box;     // registers as the block holds them
  box_t                  cur_ref;     // last setting written, used to aim items
  bit                    idle_en = 1'b1;
  bit                    hold_req = 1'b0;
  bit                    hold_done = 1'b0;
  int                    src_gap, sink_gap, hold_left, quiet_cycles;
  int                    n_bad, n_checked, n_hits, n_settings;

  oriented_box_overlap_test_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Separated on this axis when the projected center distance is nonzero
  // and reaches the projected radius sum (cross terms floored to Q.14).
  function automatic bit axis_splits(longint proj, longint own, longint k1, longint e1,
                                     longint k2, longint e2);
    longint rad;
    rad = own * UNIT + ((k1 * e1) >>> 14) + ((k2 * e2) >>> 14);
    return (proj != 0) && (rad <= proj);
  endfunction

  function automatic bit boxes_overlap(box_t r, box_t o);
    longint m, rcx, rcy, rdx, rdy, rzl, rzh, ocx, ocy, odx, ody, ozl, ozh;
    longint rl, rw, ol, ow, ddx, ddy, c, s;
    m = o.margin;
    rcx = r.cx;  rcy = r.cy;  rdx = r.dx;  rdy = r.dy;  rzl = r.zl;  rzh = r.zh;
    ocx = o.cx;  ocy = o.cy;  odx = o.dx;  ody = o.dy;  ozl = o.zl;  ozh = o.zh;
    rl = r.hl;  rw = r.hw;  ol = o.hl;  ow = o.hw;
    // height intervals first, both widened by the margin
    if (ozh + m < rzl - m || ozl - m > rzh + m) return 1'b0;
    rl += m;  rw += m;  ol += m;  ow += m;
    ddx = rcx - ocx;
    ddy = rcy - ocy;
    c = mag(rdx * odx + rdy * ody);
    s = mag(rdx * ody - rdy * odx);
    if (axis_splits(mag(ddx * rdx + ddy * rdy), rl, c, ol, s, ow)) return 1'b0;
    if (axis_splits(mag(ddy * rdx - ddx * rdy), rw, s, ol, c, ow)) return 1'b0;
    if (axis_splits(mag(ddx * odx + ddy * ody), ol, c, rl, s, rw)) return 1'b0;
    if (axis_splits(mag(ddy * odx - ddx * ody), ow, s, rl, c, rw)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic box_t box_of(input longint cx, cy, dx, dy, hl, hw, zl, zh, m);
    box_t b;
    b.cx = cx;  b.cy = cy;  b.dx = dx;  b.dy = dy;  b.hl = hl;  b.hw = hw;
    b.zl = zl;  b.zh = zh;  b.margin = m;
    return b;
  endfunction

  function automatic box_t unpack_box(logic [IN_TDATA_W-1:0] t);
    box_t b;
    b.cx = t[31:0];     b.cy = t[63:32];    b.dx = t[79:64];    b.dy = t[95:80];
    b.hl = t[126:96];   b.hw = t[157:127];  b.zl = t[189:158];  b.zh = t[221:190];
    b.margin = t[245:222];
    return b;
  endfunction

  // Uniform offset in [-span, span]
  function automatic longint pick_off(longint span);
    longint u;
    u = longint'({$urandom(), $urandom()} >> 2);
    return (u % (2 * span + 1)) - span;
  endfunction

  // Unit direction at a whole-degree angle, {dy, dx} in Q1.14
  function automatic logic [31:0] unit_dir();
    real a;
    logic signed [15:0] ux, uy;
    a = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    ux = $rtoi($floor($cos(a) * 16384.0 + 0.5));
    uy = $rtoi($floor($sin(a) * 16384.0 + 0.5));
    return {uy, ux};
  endfunction

  // Mostly small sizes, scattered over several octaves
  function automatic longint rand_half();
    return $urandom_range(0, 1 << $urandom_range(4, 20));
  endfunction

  function automatic box_t pick_ref(int ph);
    box_t r;
    logic [31:0] d;
    longint z0;
    case (ph)
      0: r = box_of('h7FFF_FFFF, -64'sh8000_0000, -32768, 32767, MAX_HALF, MAX_HALF,
                    -64'sh8000_0000, 'h7FFF_FFFF, 0);
      1: r = box_of(0, 0, 0, 0, 0, 0, 0, 0, 0);
      default: begin
        d = unit_dir();
        z0 = pick_off(1 << 16);
        r = box_of(pick_off(1 << 24), pick_off(1 << 24), longint'(signed'(d[15:0])),
                   longint'(signed'(d[31:16])), rand_half(), rand_half(), z0,
                   z0 + $urandom_range(0, 1 << 16), 0);
        // reversed heights in one setting, an off-unit direction in another
        if (ph == 5) r.zh = z0 - $urandom_range(1, 1 << 12);
        if (ph == 6) r.dx = $urandom();
      end
    endcase
    return r;
  endfunction

  // Box near the reference so that all axes and the height test decide
  function automatic box_t shape_item(box_t r);
    box_t o;
    logic [31:0] d;
    longint span, zl, zh;
    if ($urandom_range(0, 4) == 0) begin
      o.cx = $urandom();  o.cy = $urandom();  o.dx = $urandom();  o.dy = $urandom();
      o.hl = $urandom();  o.hw = $urandom();  o.zl = $urandom();  o.zh = $urandom();
      o.margin = $urandom();
      return o;
    end
    d = unit_dir();
    o.dx = d[15:0];
    o.dy = d[31:16];
    if ($urandom_range(0, 15) == 0) o.dx = $urandom();
    o.hl = rand_half();
    o.hw = rand_half();
    span = longint'(r.hl) + longint'(r.hw) + longint'(o.hl) + longint'(o.hw) + 1;
    o.cx = longint'(r.cx) + pick_off(span);
    o.cy = longint'(r.cy) + pick_off(span);
    zl = r.zl;
    zh = r.zh;
    case ($urandom_range(0, 5))
      0: begin
        zl = zh + int'($urandom_range(0, 2)) - 1;
        zh = zl + $urandom_range(0, 4096);
      end
      1: begin
        zh = zl + int'($urandom_range(0, 2)) - 1;
        zl = zh - $urandom_range(0, 4096);
      end
      default: begin
        zl = zl - $urandom_range(0, 4096);
        zh = zh + $urandom_range(0, 4096);
      end
    endcase
    o.zl = zl;
    o.zh = zh;
    case ($urandom_range(0, 7))
      0:       o.margin = $urandom();
      1, 2:    o.margin = int'($urandom_range(0, 512)) - 256;
      default: o.margin = 0;
    endcase
    return o;
  endfunction

  task automatic queue_box(box_t b);
    box_pending.push_back({2'b00, b.margin, b.zh, b.zl, b.hw, b.hl, b.dy, b.dx, b.cy, b.cx});
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Write all eight registers; unused upper bits carry junk that must be dropped
  task automatic load_ref(box_t b);
    logic [15:0] junk;
    junk = $urandom();
    write_reg(REG_CENTER_X, b.cx);
    write_reg(REG_CENTER_Y, b.cy);
    write_reg(REG_DIR_X, {junk, b.dx});
    write_reg(REG_DIR_Y, {~junk, b.dy});
    write_reg(REG_HALF_LENGTH, {junk[0], b.hl});
    write_reg(REG_HALF_WIDTH, {junk[1], b.hw});
    write_reg(REG_Z_LOW, b.zl);
    write_reg(REG_Z_HIGH, b.zh);
    cur_ref = b;
    n_settings++;
    @(negedge clk);
  endtask

  // Wait until every offered box has been answered
  task automatic drain();
    do @(negedge clk);
    while (box_pending.size() != 0 || s_axis_tvalid || overlap_expected.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Input driver: advance on a transfer, insert random gaps
  always @(posedge clk) begin : feed_boxes
    logic                  nxt_valid;
    logic [IN_TDATA_W-1:0] nxt_data;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      nxt_valid = 1'b0;
      nxt_data  = s_axis_tdata;
      if (src_gap > 0) begin
        src_gap--;
      end else if (box_pending.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = box_pending.pop_front();
        if (idle_en && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 15);
      end
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin : take_results
    logic nxt_ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap  = 0;
      hold_left = 0;
    end else begin
      nxt_ready = 1'b1;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        nxt_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        sink_gap  = $urandom_range(0, 14);
        nxt_ready = 1'b0;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // Check results, predict accepted boxes, track register writes
  always @(posedge clk) begin : score
    bit want;
    if (rst) begin
      ref_box = box_of(0, 0, UNIT, 0, 0, 0, 0, 0, 0);
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlap_expected.size() == 0) begin
          $error("overlap: unexpected result, actual %0b", m_axis_tdata[0]);
          n_bad++;
        end else begin
          want = overlap_expected.pop_front();
          n_checked++;
          if (m_axis_tdata[0] !== want) begin
            $error("overlap: expected %0b, actual %0b", want, m_axis_tdata[0]);
            n_bad++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = boxes_overlap(ref_box, unpack_box(s_axis_tdata));
        overlap_expected.push_back(want);
        if (want) n_hits++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:    ref_box.cx = cfg_data;
          REG_CENTER_Y:    ref_box.cy = cfg_data;
          REG_DIR_X:       ref_box.dx = cfg_data[15:0];
          REG_DIR_Y:       ref_box.dy = cfg_data[15:0];
          REG_HALF_LENGTH: ref_box.hl = cfg_data[30:0];
          REG_HALF_WIDTH:  ref_box.hw = cfg_data[30:0];
          REG_Z_LOW:       ref_box.zl = cfg_data;
          REG_Z_HIGH:      ref_box.zh = cfg_data;
        endcase
      end
    end
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    longint bx, by;
    bx = 'h1000;
    by = -'h800;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: point box at the origin
    queue_box(box_of(0, 0, UNIT, 0, 0, 0, 0, 0, 0));
    queue_box(box_of(0, 'h100, UNIT, 0, 'h80, 'h80, 0, 0, 0));
    drain();

    // directed cases around a small axis-aligned box
    load_ref(box_of(bx, by, UNIT, 0, 'h800, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx + 'h4000, by, UNIT, 0, 'h800, 'h400, 0, 'h1000, 0));
    // faces exactly touching count as separated, one LSB closer overlaps
    queue_box(box_of(bx + 'hC00, by, UNIT, 0, 'h400, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx + 'hBFF, by, UNIT, 0, 'h400, 'h400, 0, 'h1000, 0));
    // apart along the normal, zero projection on the direction
    queue_box(box_of(bx, by + 'h2000, UNIT, 0, 'h800, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, 'h1001, 'h2000, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, 'h1000, 'h2000, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, -'h1000, -1, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, -'h1000, -1, 1));
    // margins that make extents negative or huge
    queue_box(box_of(bx + 'h100, by, UNIT, 0, 'h200, 'h200, 0, 'h1000, -'h500));
    queue_box(box_of(bx + 'h100000, by, UNIT, 0, 0, 0, 0, 'h1000, MARGIN_MAX));
    queue_box(box_of(bx + 'h100, by, UNIT, 0, 'h800, 'h400, 0, 'h1000, MARGIN_MIN));
    // rotated, null and out-of-range directions
    queue_box(box_of(bx + 'hE00, by + 'hA00, 11585, 11585, 'h200, 'h200, 0, 'h1000, 0));
    queue_box(box_of(bx + 'hA00, by, 0, UNIT, 'h400, 'h100, 0, 'h1000, 0));
    queue_box(box_of(bx + 'h300, by + 'h300, 0, 0, 'h400, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx + 'h300, by - 'h300, -32768, 32767, 'h400, 'h400, 0, 'h1000, 0));
    queue_box(box_of(bx, by, UNIT, 0, 'h800, 'h400, 'h2000, -'h2000, 0));
    // field extremes
    queue_box(box_of(-64'sh8000_0000, 'h7FFF_FFFF, -UNIT, 0, MAX_HALF, MAX_HALF,
                     -64'sh8000_0000, 'h7FFF_FFFF, 0));
    queue_box(box_of(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    queue_box(box_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random boxes aimed at a new reference box in each phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_ref(pick_ref(ph));
      if (ph == 3) hold_req = 1'b1;
      if (ph == RAND_PHASES - 1) idle_en = 1'b0;
      repeat (PHASE_ITEMS) queue_box(shape_item(cur_ref));
      drain();
    end

    repeat (12) @(posedge clk);
    if (overlap_expected.size() != 0)
      $error("overlap: %0d expected results never arrived", overlap_expected.size());
    $display("Checked %0d results (%0d overlapping) over %0d reference box settings,",
             n_checked, n_hits, n_settings);
    $display("including field extremes, touching faces, margins and one long output stall.");
    if (n_bad == 0 && overlap_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/obot_pkg.sv
sv/obot_axis.sv
sv/oriented_box_overlap_test_top.sv
tb/oriented_box_overlap_test_top_tb.sv
